// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the keyed record index RTL.
// Depends on nothing; include by bare file name inside a module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define KRIB_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("krib assertion failed");

// next-cycle implication, disabled while reset is low
`define KRIB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("krib assertion failed");

`endif

// ===== rtl/krib_pkg.sv =====
// Package for the keyed record index builder/lookup block.
// Field widths, mode/status codes, command kinds and the queued command type.
`timescale 1ns / 1ps

package krib_pkg;

	localparam int MODE_W   = 2;
	localparam int KEY_W    = 8;
	localparam int ITEM_W   = 8;
	localparam int OFS_W    = 32;
	localparam int STATUS_W = 2;
	localparam int IDX_W    = 15;
	localparam int SLOT_FW  = 16;
	localparam int CMDQ_DEPTH = 2;

	localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
	localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

	typedef enum logic [2:0] {
		K_CLEAR,
		K_APPEND,
		K_REJECT,
		K_LOOKUP,
		K_MISS,
		K_BADMODE
	} kind_t;

	typedef struct packed {
		kind_t               kind;
		logic [SLOT_FW-1:0]  slot;
		logic [KEY_W-1:0]    major_idx;
		logic [KEY_W-1:0]    minor;
		logic [ITEM_W-1:0]   item;
		logic [OFS_W-1:0]    offset;
	} cmd_t;

endpackage

// ===== rtl/krib_req_if.sv =====
// Request channel interface: valid/ready plus the input item fields.
// Depends on krib_pkg.
`timescale 1ns / 1ps

interface krib_req_if import krib_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [MODE_W-1:0]   mode;
	logic [KEY_W-1:0]    group_major;
	logic [KEY_W-1:0]    group_minor;
	logic [ITEM_W-1:0]   item_number;
	logic [OFS_W-1:0]    payload_offset;

	modport source (
		output valid, mode, group_major, group_minor, item_number, payload_offset,
		input  ready
	);
	modport sink (
		input  valid, mode, group_major, group_minor, item_number, payload_offset,
		output ready
	);
endinterface

// ===== rtl/krib_rsp_if.sv =====
// Response channel interface: valid/ready plus the result item fields.
// Depends on krib_pkg.
`timescale 1ns / 1ps

interface krib_rsp_if import krib_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [IDX_W-1:0]    record_index;
	logic [OFS_W-1:0]    found_offset;

	modport source (
		output valid, status, record_index, found_offset,
		input  ready
	);
	modport sink (
		input  valid, status, record_index, found_offset,
		output ready
	);
endinterface

// ===== rtl/krib_front.sv =====
// Front end: takes request transfers, checks keys, builds the table slot
// and pushes a classified command. Depends on krib_pkg and krib_req_if.
`timescale 1ns / 1ps

module krib_front import krib_pkg::*; #(
	parameter int MAJOR_KEYS = 84,
	parameter int MINOR_KEYS = 152
) (
	krib_req_if.sink   req,
	input  logic       sweep_busy,
	output logic       push_valid,
	input  logic       push_ready,
	output cmd_t       push_data
);

	logic             major_ok;
	logic             minor_ok;
	logic [KEY_W-1:0] maj_idx;
	logic [KEY_W-1:0] min_idx;

	assign req.ready  = push_ready && !sweep_busy;
	assign push_valid = req.valid && !sweep_busy;

	assign major_ok = (req.group_major != '0) && (req.group_major <= KEY_W'(MAJOR_KEYS));
	assign minor_ok = (req.group_minor != '0) && (req.group_minor <= KEY_W'(MINOR_KEYS));
	assign maj_idx  = req.group_major - KEY_W'(1);
	assign min_idx  = req.group_minor - KEY_W'(1);

	always_comb begin
		push_data.slot      = SLOT_FW'(SLOT_FW'(maj_idx) * SLOT_FW'(MINOR_KEYS))
			+ SLOT_FW'(min_idx);
		push_data.major_idx = maj_idx;
		push_data.minor     = req.group_minor;
		push_data.item      = req.item_number;
		push_data.offset    = req.payload_offset;
		unique case (req.mode)
			MODE_CLEAR:  push_data.kind = K_CLEAR;
			MODE_APPEND: push_data.kind = (major_ok && minor_ok) ? K_APPEND : K_REJECT;
			MODE_LOOKUP: push_data.kind = (major_ok && minor_ok) ? K_LOOKUP : K_MISS;
			MODE_UNUSED: push_data.kind = K_BADMODE;
		endcase
	end

endmodule

// ===== rtl/krib_cmd_fifo.sv =====
// Short command queue between front and back ends.
// Depends on krib_pkg (cmd_t, CMDQ_DEPTH).
`timescale 1ns / 1ps

module krib_cmd_fifo import krib_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_data
);

	localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

	cmd_t             mem_q [CMDQ_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic             push_fire;
	logic             pop_fire;

	assign push_ready = fill_q != CNT_W'(CMDQ_DEPTH);
	assign pop_valid  = fill_q != '0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push_fire) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push_fire) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop_fire) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push_fire && !pop_fire) begin
				fill_q <= fill_q + CNT_W'(1);
			end else if (pop_fire && !push_fire) begin
				fill_q <= fill_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== rtl/krib_back.sv =====
// Back end: pair table, highest-minor table and record memory, the
// command sequencer, clearing sweep and result register.
// Depends on krib_pkg and krib_rsp_if.
`timescale 1ns / 1ps

module krib_back import krib_pkg::*; #(
	parameter int MAJOR_KEYS  = 84,
	parameter int MINOR_KEYS  = 152,
	parameter int MAX_RECORDS = 32768
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pop_valid,
	output logic       pop_ready,
	input  cmd_t       pop_data,
	krib_rsp_if.source rsp,
	output logic       sweep_busy
);

	localparam int PAIR_SLOTS = MAJOR_KEYS * MINOR_KEYS;
	localparam int SLOT_W = (PAIR_SLOTS > 1) ? $clog2(PAIR_SLOTS) : 1;
	localparam int MAJ_W  = (MAJOR_KEYS > 1) ? $clog2(MAJOR_KEYS) : 1;
	localparam int REC_W  = $clog2(MAX_RECORDS);
	localparam int HELD_W = $clog2(MAX_RECORDS + 1);
	localparam int CNT_W  = HELD_W;
	localparam int CMP_W  = (CNT_W > ITEM_W) ? CNT_W : ITEM_W;
	localparam int SUM_W  = CMP_W + 1;
	localparam int PAIR_W = 1 + CNT_W + REC_W;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_EXEC  = 2'd1;
	localparam logic [1:0] S_FETCH = 2'd2;
	localparam logic [1:0] S_CLEAR = 2'd3;

	logic [PAIR_W-1:0] pair_mem [PAIR_SLOTS];
	logic [KEY_W-1:0]  hi_mem [MAJOR_KEYS];
	logic [OFS_W-1:0]  rec_mem [MAX_RECORDS];

	logic [1:0]          state_q;
	cmd_t                cmd_q;
	logic [SLOT_W-1:0]   clr_ptr_q;
	logic [HELD_W-1:0]   held_q;
	logic                invalid_q;
	logic [PAIR_W-1:0]   pair_rd_q;
	logic [KEY_W-1:0]    hi_rd_q;
	logic [OFS_W-1:0]    rec_rd_q;
	logic                res_valid_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [IDX_W-1:0]    res_index_q;
	logic [OFS_W-1:0]    res_offset_q;

	logic                pop_fire;
	logic                exec;
	logic                seen;
	logic [CNT_W-1:0]    cnt;
	logic [REC_W-1:0]    first;
	logic                full;
	logic [SUM_W-1:0]    lk_sum;
	logic                lk_hit;
	logic [PAIR_W-1:0]   pair_new;
	logic                res_load;
	logic [STATUS_W-1:0] res_status;
	logic [REC_W-1:0]    res_idx;
	logic                fetch;
	logic                app_wr;
	logic                hi_wr;
	logic                start_clear;
	logic                set_invalid;

	assign pop_ready  = (state_q == S_IDLE) && !res_valid_q;
	assign pop_fire   = pop_valid && pop_ready;
	assign exec       = state_q == S_EXEC;
	assign sweep_busy = state_q == S_CLEAR;

	assign rsp.valid        = res_valid_q;
	assign rsp.status       = res_status_q;
	assign rsp.record_index = res_index_q;
	assign rsp.found_offset = res_offset_q;

	assign seen  = pair_rd_q[PAIR_W-1];
	assign cnt   = pair_rd_q[REC_W +: CNT_W];
	assign first = pair_rd_q[REC_W-1:0];
	assign full  = held_q == HELD_W'(MAX_RECORDS);

	assign lk_sum = SUM_W'(first) + SUM_W'(cmd_q.item) - SUM_W'(1);
	assign lk_hit = seen && (cmd_q.item != '0) && (CMP_W'(cmd_q.item) <= CMP_W'(cnt))
		&& (cmd_q.minor <= hi_rd_q) && (lk_sum < SUM_W'(held_q));

	assign pair_new = seen ? {1'b1, cnt + CNT_W'(1), first}
		: {1'b1, CNT_W'(1), held_q[REC_W-1:0]};

	always_comb begin
		res_load    = 1'b0;
		res_status  = ST_INVALID;
		res_idx     = '0;
		fetch       = 1'b0;
		app_wr      = 1'b0;
		hi_wr       = 1'b0;
		start_clear = 1'b0;
		set_invalid = 1'b0;
		if (exec) begin
			unique case (cmd_q.kind)
				K_CLEAR: begin
					res_load    = 1'b1;
					res_status  = ST_OK;
					start_clear = 1'b1;
				end
				K_APPEND: begin
					res_load = 1'b1;
					if (full) begin
						set_invalid = 1'b1;
						res_status  = ST_FULL;
					end else begin
						app_wr     = 1'b1;
						hi_wr      = !seen && (cmd_q.minor > hi_rd_q);
						res_status = ST_OK;
						res_idx    = held_q[REC_W-1:0];
					end
				end
				K_REJECT: begin
					res_load    = 1'b1;
					set_invalid = 1'b1;
				end
				K_LOOKUP: begin
					if (invalid_q) begin
						res_load = 1'b1;
					end else if (lk_hit) begin
						fetch   = 1'b1;
						res_idx = lk_sum[REC_W-1:0];
					end else begin
						res_load   = 1'b1;
						res_status = ST_NOT_FOUND;
					end
				end
				K_MISS: begin
					res_load   = 1'b1;
					res_status = invalid_q ? ST_INVALID : ST_NOT_FOUND;
				end
				default: begin
					res_load = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (sweep_busy) begin
			pair_mem[clr_ptr_q] <= '0;
		end else if (app_wr) begin
			pair_mem[cmd_q.slot[SLOT_W-1:0]] <= pair_new;
		end
		if (pop_fire) begin
			pair_rd_q <= pair_mem[pop_data.slot[SLOT_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (sweep_busy && ((SLOT_W + 1)'(clr_ptr_q) < (SLOT_W + 1)'(MAJOR_KEYS))) begin
			hi_mem[clr_ptr_q[MAJ_W-1:0]] <= '0;
		end else if (hi_wr) begin
			hi_mem[cmd_q.major_idx[MAJ_W-1:0]] <= cmd_q.minor;
		end
		if (pop_fire) begin
			hi_rd_q <= hi_mem[pop_data.major_idx[MAJ_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (app_wr) begin
			rec_mem[held_q[REC_W-1:0]] <= cmd_q.offset;
		end
		if (fetch) begin
			rec_rd_q <= rec_mem[lk_sum[REC_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (pop_fire) begin
			cmd_q <= pop_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_ptr_q    <= '0;
			held_q       <= '0;
			invalid_q    <= 1'b0;
			res_valid_q  <= 1'b0;
			res_status_q <= ST_OK;
			res_index_q  <= '0;
			res_offset_q <= '0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop_fire) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (res_load) begin
						res_valid_q  <= 1'b1;
						res_status_q <= res_status;
						res_index_q  <= IDX_W'(res_idx);
						res_offset_q <= '0;
					end else begin
						res_index_q <= IDX_W'(res_idx);
					end
					if (set_invalid) begin
						invalid_q <= 1'b1;
					end
					if (app_wr) begin
						held_q <= held_q + HELD_W'(1);
					end
					if (start_clear) begin
						held_q    <= '0;
						invalid_q <= 1'b0;
						clr_ptr_q <= '0;
						state_q   <= S_CLEAR;
					end else if (fetch) begin
						state_q <= S_FETCH;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_FETCH: begin
					res_valid_q  <= 1'b1;
					res_status_q <= ST_OK;
					res_offset_q <= rec_rd_q;
					state_q      <= S_IDLE;
				end
				S_CLEAR: begin
					clr_ptr_q <= clr_ptr_q + SLOT_W'(1);
					if (clr_ptr_q == SLOT_W'(PAIR_SLOTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

endmodule

// ===== rtl/keyed_record_index_builder_lookup_unit.sv =====
// Top level of the keyed record index builder/lookup block.
// Depends on krib_pkg, krib_req_if, krib_rsp_if, krib_front, krib_cmd_fifo,
// krib_back and assert_macros.svh.
//
//   port  dir   carries
//   ----  ----  --------------------------------------------------------
//   req   sink  mode, group_major, group_minor, item_number, payload_offset
//   rsp   src   status, record_index, found_offset (one per request)
//
// A result is registered after its command leaves the queue and the pair table is
// read; a found lookup adds a record memory read before the result register.
// The back end takes a new command only once the last result has left on rsp.
// Reset and every clear run a sweep over all MAJOR_KEYS * MINOR_KEYS pair table
// entries (12768 by default), one entry per cycle; req is held off then.
// Up to two commands wait in the queue; a new one is popped only once the result
// register is empty; rsp back-pressure holds the back end, and req on a full queue.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module keyed_record_index_builder_lookup_unit import krib_pkg::*; #(
	parameter int MAJOR_KEYS  = 84,
	parameter int MINOR_KEYS  = 152,
	parameter int MAX_RECORDS = 32768
) (
	input  logic       clk,
	input  logic       arst_n,
	krib_req_if.sink   req,
	krib_rsp_if.source rsp
);

	logic push_valid;
	logic push_ready;
	cmd_t push_data;
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_data;
	logic sweep_busy;
	logic rsp_fail;
	logic rsp_zero;

	assign rsp_fail = rsp.valid && (rsp.status != ST_OK);
	assign rsp_zero = (rsp.record_index == '0) && (rsp.found_offset == '0);

	krib_front #(
		.MAJOR_KEYS (MAJOR_KEYS),
		.MINOR_KEYS (MINOR_KEYS)
	) u_front (
		.req        (req),
		.sweep_busy (sweep_busy),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	krib_cmd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	krib_back #(
		.MAJOR_KEYS  (MAJOR_KEYS),
		.MINOR_KEYS  (MINOR_KEYS),
		.MAX_RECORDS (MAX_RECORDS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data),
		.rsp        (rsp),
		.sweep_busy (sweep_busy)
	);

	`KRIB_ASSERT_IMPLY(a_no_take_in_sweep, clk, arst_n, sweep_busy, !req.ready)
	`KRIB_ASSERT_IMPLY(a_take_has_room, clk, arst_n, req.valid && req.ready, push_ready)
	`KRIB_ASSERT_IMPLY(a_fail_fields_zero, clk, arst_n, rsp_fail, rsp_zero)
	`KRIB_ASSERT_NEXT(a_one_in_flight, clk, arst_n, pop_valid && pop_ready, !pop_ready)

endmodule
